// ===== hdl/rbst_pkg.sv =====
// shared constants for the ray versus box slab test
`default_nettype none
package rbst_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int THR_WIDTH       = 16;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd7;
  localparam int FRAC_BITS       = 16;
  localparam int NUM_AXES        = 3;
  localparam int NUM_SLABS       = 6;

  // width of one classified item in the queue for a coordinate width
  function automatic int item_width(input int cw);
    return NUM_SLABS * (2 * cw + 2) + NUM_AXES * cw;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/rbst_if.sv =====
// valid/ready channel interfaces for ray items and hit results
`default_nettype none
interface rbst_in_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] origin_x;
  logic [W-1:0] origin_y;
  logic [W-1:0] origin_z;
  logic [W-1:0] dir_x;
  logic [W-1:0] dir_y;
  logic [W-1:0] dir_z;
  logic [W-1:0] box_lo_x;
  logic [W-1:0] box_lo_y;
  logic [W-1:0] box_lo_z;
  logic [W-1:0] box_hi_x;
  logic [W-1:0] box_hi_y;
  logic [W-1:0] box_hi_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                output ready);
endinterface

interface rbst_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

// ===== hdl/rbst_front.sv =====
// front end: takes ray items, forms slab numerators and parallel cases
`default_nettype none
module rbst_front
  import rbst_pkg::*;
#(
  parameter int W = COORD_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [THR_WIDTH-1:0]      cfg_wr_data,
  rbst_in_if.sink                        in_ch,
  input  wire logic                      q_ready,
  output logic                           q_push,
  output logic [item_width(W)-1:0]       q_data
);
  localparam int SLW = 2 * W + 2;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic [THR_WIDTH-1:0] thr;
  logic [NUM_AXES-1:0][W-1:0] org, dir, lo, hi;

  // parallel threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  assign org[0] = in_ch.origin_x;
  assign org[1] = in_ch.origin_y;
  assign org[2] = in_ch.origin_z;
  assign dir[0] = in_ch.dir_x;
  assign dir[1] = in_ch.dir_y;
  assign dir[2] = in_ch.dir_z;
  assign lo[0]  = in_ch.box_lo_x;
  assign lo[1]  = in_ch.box_lo_y;
  assign lo[2]  = in_ch.box_lo_z;
  assign hi[0]  = in_ch.box_hi_x;
  assign hi[1]  = in_ch.box_hi_y;
  assign hi[2]  = in_ch.box_hi_z;

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  // per axis direction magnitude and per slab edge classification
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic         dneg;
    logic [W-1:0] dmag;
    logic         par;

    assign dneg = dir[a][W-1];
    assign dmag = dneg ? (~dir[a] + 1'b1) : dir[a];
    assign par  = (dmag == '0) || (dmag < {{(W-THR_WIDTH){1'b0}}, thr});
    assign q_data[NUM_SLABS*SLW + a*W +: W] = dmag;

    for (genvar e = 0; e < 2; e++) begin : g_edge
      localparam int S = 2 * a + e;
      logic [W-1:0] edge_v;
      logic [W:0]   diff;
      logic [W:0]   adiff;
      logic         nneg;
      logic [W-1:0] nmag;
      logic [W-1:0] spec;

      assign edge_v = (e == 1) ? hi[a] : lo[a];
      assign diff   = {edge_v[W-1], edge_v} - {org[a][W-1], org[a]};
      assign nneg   = diff[W];
      assign adiff  = nneg ? (~diff + 1'b1) : diff;
      assign nmag   = adiff[W-1:0];
      assign spec   = (nmag == '0) ? ((e == 1) ? VMAX : VMIN) : (nneg ? VMIN : VMAX);

      assign q_data[S*SLW +: W]     = nmag;
      assign q_data[S*SLW + W +: W] = spec;
      assign q_data[S*SLW + 2*W]    = par;
      assign q_data[S*SLW + 2*W+1]  = (nneg ^ dneg) && (nmag != '0);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rbst_fifo.sv =====
// two-entry queue between the front end and the divider pipeline
`default_nettype none
module rbst_fifo
  import rbst_pkg::*;
#(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  output logic               can_push,
  input  wire logic          pop,
  output logic               can_pop,
  output logic [DW-1:0]      pop_data
);
  logic [1:0][DW-1:0] mem;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign can_push = (count != 2'd2);
  assign can_pop  = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && can_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop && can_pop};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rbst_back.sv =====
// back end: pipelined restoring dividers, saturation and interval test
`default_nettype none
module rbst_back
  import rbst_pkg::*;
#(
  parameter int W = COORD_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire logic [item_width(W)-1:0] q_data,
  output logic                      q_pop,
  rbst_out_if.source                out_ch
);
  localparam int SLW = 2 * W + 2;
  localparam int QB  = W + FRAC_BITS;
  localparam logic [QB-1:0] LIM_POS = QB'({1'b0, {(W-1){1'b1}}});
  localparam logic [QB-1:0] LIM_NEG = QB'({1'b1, {(W-1){1'b0}}});

  logic adv;
  logic out_valid, out_hit;

  logic [QB:0]                           v;
  logic [QB:0][NUM_SLABS-1:0][QB-1:0]    dq;
  logic [QB:0][NUM_SLABS-1:0][W-1:0]     rem;
  logic [QB:0][NUM_SLABS-1:0][W-1:0]     sv;
  logic [QB:0][NUM_SLABS-1:0]            sp, qn;
  logic [QB:0][NUM_AXES-1:0][W-1:0]      dm;

  logic                                  fv_valid;
  logic signed [NUM_SLABS-1:0][W-1:0]    fv;

  // whole pipeline moves unless a finished item is held at the output
  assign adv   = !out_valid || out_ch.ready;
  assign q_pop = adv;

  // load stage from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= q_valid;
    end
  end

  for (genvar s = 0; s < NUM_SLABS; s++) begin : g_load
    always_ff @(posedge clk) begin
      if (adv) begin
        dq[0][s]  <= {q_data[s*SLW +: W], {FRAC_BITS{1'b0}}};
        rem[0][s] <= '0;
        sv[0][s]  <= q_data[s*SLW + W +: W];
        sp[0][s]  <= q_data[s*SLW + 2*W];
        qn[0][s]  <= q_data[s*SLW + 2*W + 1];
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_load_dm
    always_ff @(posedge clk) begin
      if (adv) begin
        dm[0][a] <= q_data[NUM_SLABS*SLW + a*W +: W];
      end
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dm[k+1] <= dm[k];
        sv[k+1] <= sv[k];
        sp[k+1] <= sp[k];
        qn[k+1] <= qn[k];
      end
    end

    for (genvar s = 0; s < NUM_SLABS; s++) begin : g_slab
      logic [W:0] r2, rsub;
      logic       ge;

      assign r2   = {rem[k][s], dq[k][s][QB-1]};
      assign ge   = (r2 >= {1'b0, dm[k][s/2]});
      assign rsub = r2 - {1'b0, dm[k][s/2]};

      always_ff @(posedge clk) begin
        if (adv) begin
          rem[k+1][s] <= ge ? rsub[W-1:0] : r2[W-1:0];
          dq[k+1][s]  <= {dq[k][s][QB-2:0], ge};
        end
      end
    end
  end

  // saturate and sign each slab distance
  always_ff @(posedge clk) begin
    if (rst) begin
      fv_valid <= 1'b0;
    end else if (adv) begin
      fv_valid <= v[QB];
    end
  end

  for (genvar s = 0; s < NUM_SLABS; s++) begin : g_final
    logic [QB-1:0] lim, sat;
    logic [W-1:0]  mag;

    assign lim = qn[QB][s] ? LIM_NEG : LIM_POS;
    assign sat = (dq[QB][s] > lim) ? lim : dq[QB][s];
    assign mag = sat[W-1:0];

    always_ff @(posedge clk) begin
      if (adv) begin
        fv[s] <= sp[QB][s] ? sv[QB][s] : (qn[QB][s] ? (~mag + 1'b1) : mag);
      end
    end
  end

  // order each slab, then largest entry against smallest exit
  logic signed [NUM_AXES-1:0][W-1:0] tn, tx;
  logic signed [W-1:0] ent01, ext01, entry_t, exit_t;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_order
    logic lt;
    assign lt    = $signed(fv[2*a]) < $signed(fv[2*a+1]);
    assign tn[a] = lt ? fv[2*a]   : fv[2*a+1];
    assign tx[a] = lt ? fv[2*a+1] : fv[2*a];
  end

  assign ent01   = ($signed(tn[0]) > $signed(tn[1])) ? tn[0] : tn[1];
  assign ext01   = ($signed(tx[0]) < $signed(tx[1])) ? tx[0] : tx[1];
  assign entry_t = ($signed(ent01) > $signed(tn[2])) ? ent01 : tn[2];
  assign exit_t  = ($signed(ext01) < $signed(tx[2])) ? ext01 : tx[2];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit <= ($signed(entry_t) <= $signed(exit_t));
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.hit   = out_hit;
endmodule
`default_nettype wire

// ===== hdl/ray_box_slab_test.sv =====
// top level of the ray versus axis-aligned box slab test
//
// Takes one ray/box item per cycle and returns one hit bit per item, in order. Each item
// is classified in the front end (slab numerators, direction magnitudes, parallel cases
// against parallel_threshold) and goes through a two-entry queue into six restoring
// dividers pipelined one quotient bit per stage, COORD_WIDTH+16 stages deep. Throughput
// is one item per cycle while the output is taken. A stalled output holds the whole
// divider pipeline, and input is taken until the queue fills. Write the threshold only
// while no item is in flight.
`default_nettype none
module ray_box_slab_test
  import rbst_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [THR_WIDTH-1:0] cfg_wr_data,
  rbst_in_if.sink                   in_ch,
  rbst_out_if.source                out_ch
);
  localparam int DW = item_width(COORD_WIDTH);

  logic          f_push, f_can_push, f_pop, f_can_pop;
  logic [DW-1:0] f_wdata, f_rdata;

  // classify incoming items
  rbst_front #(.W(COORD_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_ready     (f_can_push),
    .q_push      (f_push),
    .q_data      (f_wdata)
  );

  // decoupling queue
  rbst_fifo #(.DW(DW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (f_wdata),
    .can_push  (f_can_push),
    .pop       (f_pop),
    .can_pop   (f_can_pop),
    .pop_data  (f_rdata)
  );

  // dividers and interval test
  rbst_back #(.W(COORD_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (f_can_pop),
    .q_data  (f_rdata),
    .q_pop   (f_pop),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire

// ===== hdl/rbst_checker.sv =====
// port-level checks for the slab test, bound to the top level
`default_nettype none
module rbst_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_hit
);
  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("result dropped or changed while stalled");

  // nothing comes out right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // the queue is empty after reset
  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // input only backs up when the output stalled the cycle before
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");
endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit)
);
`default_nettype wire

// ===== dv/tb_ray_box_slab_test.sv =====
// testbench for the ray versus box slab test: directed table, then random rays, checked by a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_ray_box_slab_test;
  import rbst_pkg::*;

  localparam int W = COORD_WIDTH_DEF;
  localparam int NUM_RANDOM = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MAX = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE = 32'h0001_0000;

  typedef logic signed [W-1:0] coord_t;
  typedef struct packed {
    coord_t ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz;
  } ray_box_t;
  // expect_hit: 0 or 1 typed in, 2 means take the predictor
  typedef struct {
    ray_box_t rb;
    int expect_hit;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [THR_WIDTH-1:0] cfg_wr_data;
  rbst_in_if #(.W(W)) in_ch ();
  rbst_out_if out_ch ();

  ray_box_slab_test #(.COORD_WIDTH(W)) i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  logic [THR_WIDTH-1:0] threshold;
  bit hit_queue[$];
  int errors;
  int cycles;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // append one row to the directed table
  task automatic add_row(input ray_box_t rb, input int want);
    row_t r;
    r.rb = rb;
    r.expect_hit = want;
    rows.insert(rows.size(), r);
  endtask

  // signed distance to one slab edge, saturated, as a W-bit signed value
  function automatic coord_t slab_distance(coord_t org, coord_t dir, coord_t edge_v,
                                           bit is_hi);
    logic signed [W:0] num;
    logic [W:0] nmag;
    logic [W-1:0] dmag;
    logic [W+16:0] quot;
    bit qneg;
    num = W'(0) + $signed({edge_v[W-1], edge_v}) - $signed({org[W-1], org});
    nmag = num[W] ? -num : num;
    dmag = dir[W-1] ? -dir : dir;
    if (dmag == 0 || dmag < {16'b0, threshold}) begin
      if (nmag == 0) return is_hi ? POS_MAX : NEG_MAX;
      return num[W] ? NEG_MAX : POS_MAX;
    end
    qneg = (num[W] != dir[W-1]) && nmag != 0;
    quot = {nmag, 16'b0} / dmag;
    if (qneg) begin
      if (quot >= {18'b0, NEG_MAX}) return NEG_MAX;
      return -coord_t'(quot[W-1:0]);
    end
    if (quot > {18'b0, POS_MAX}) return POS_MAX;
    return coord_t'(quot[W-1:0]);
  endfunction

  // largest entry against smallest exit over three axes
  function automatic bit predict_hit(ray_box_t rb);
    coord_t org[3], dir[3], lo[3], hi[3];
    coord_t t0, t1, entry, leave;
    org = '{rb.ox, rb.oy, rb.oz};
    dir = '{rb.dx, rb.dy, rb.dz};
    lo = '{rb.lx, rb.ly, rb.lz};
    hi = '{rb.hx, rb.hy, rb.hz};
    entry = NEG_MAX;
    leave = POS_MAX;
    for (int a = 0; a < 3; a++) begin
      t0 = slab_distance(org[a], dir[a], lo[a], 1'b0);
      t1 = slab_distance(org[a], dir[a], hi[a], 1'b1);
      if (t0 > t1) begin
        coord_t tmp;
        tmp = t0; t0 = t1; t1 = tmp;
      end
      if (t0 > entry) entry = t0;
      if (t1 < leave) leave = t1;
    end
    return entry <= leave;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 8)) - 4;
      2: return POS_MAX - $urandom_range(0, 2);
      3: return NEG_MAX + $urandom_range(0, 2);
      4: return coord_t'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: return coord_t'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  // random ray and box, mostly well formed, in some cases with the ray aimed at the box centre
  function automatic ray_box_t rand_ray_box();
    ray_box_t rb;
    rb = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      rb.ox = rand_coord(); rb.oy = rand_coord(); rb.oz = rand_coord();
      rb.dx = rand_coord(); rb.dy = rand_coord(); rb.dz = rand_coord();
      rb.lx = coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      rb.ly = coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      rb.lz = coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      rb.hx = rb.lx + coord_t'($urandom_range(0, 32'h0008_0000));
      rb.hy = rb.ly + coord_t'($urandom_range(0, 32'h0008_0000));
      rb.hz = rb.lz + coord_t'($urandom_range(0, 32'h0008_0000));
      if ($urandom_range(0, 1)) begin
        rb.ox = 0; rb.oy = 0; rb.oz = 0;
        rb.dx = (rb.lx + rb.hx) >>> 1; rb.dy = (rb.ly + rb.hy) >>> 1;
        rb.dz = (rb.lz + rb.hz) >>> 1;
        if ($urandom_range(0, 2) == 0) rb.dy = coord_t'($urandom_range(0, 8));
      end
    end
    return rb;
  endfunction

  function automatic ray_box_t unit_box(coord_t ox, coord_t oy, coord_t oz,
                                        coord_t dx, coord_t dy, coord_t dz);
    return '{ox, oy, oz, dx, dy, dz, 0, 0, 0, ONE, ONE, ONE};
  endfunction

  // drive one item; ready is sampled between edges so the accepting edge is known
  task automatic send_item(input ray_box_t rb);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z, in_ch.dir_x, in_ch.dir_y, in_ch.dir_z,
     in_ch.box_lo_x, in_ch.box_lo_y, in_ch.box_lo_z, in_ch.box_hi_x, in_ch.box_hi_y,
     in_ch.box_hi_z} <= rb;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (W + 30) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_WIDTH-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold = value;
    @(posedge clk);
  endtask

  // result side: random stalls, compare against the oldest expectation
  initial begin
    int stall;
    bit got;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_ch.valid);
      got = out_ch.hit;
      @(posedge clk);
      if (hit_queue.size() == 0) report("result with no item outstanding");
      else begin
        bit want;
        want = hit_queue.pop_front();
        if (got !== want) report($sformatf("hit %b, wanted %b", got, want));
      end
    end
  end

  // record expectation at each accepted item
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_ch.valid && in_ch.ready)
      hit_queue.insert(hit_queue.size(), predict_hit({in_ch.origin_x, in_ch.origin_y,
        in_ch.origin_z, in_ch.dir_x, in_ch.dir_y, in_ch.dir_z, in_ch.box_lo_x,
        in_ch.box_lo_y, in_ch.box_lo_z, in_ch.box_hi_x, in_ch.box_hi_y, in_ch.box_hi_z}));
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[ray_box_slab_test] ERROR");
      $finish;
    end
  end

  initial begin
    logic [THR_WIDTH-1:0] thr_set[4];
    errors = 0;
    cycles = 0;
    threshold = THR_RESET;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z, in_ch.dir_x, in_ch.dir_y, in_ch.dir_z,
     in_ch.box_lo_x, in_ch.box_lo_y, in_ch.box_lo_z, in_ch.box_hi_x, in_ch.box_hi_y,
     in_ch.box_hi_z} = '0;
    // directed table
    add_row(unit_box(-ONE, ONE >> 1, ONE >> 1, ONE, 0, 0), 1);
    add_row(unit_box(-ONE, 2 * ONE, ONE >> 1, ONE, 0, 0), 0);
    add_row(unit_box(-ONE, ONE, ONE >> 1, ONE, 0, 0), 1);
    add_row(unit_box(-ONE, 0, 0, ONE, 6, 0), 1);
    add_row(unit_box(-ONE, -ONE, -ONE, ONE, ONE, ONE), 1);
    add_row(unit_box(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE), 2);
    add_row(unit_box(0, 0, 0, 0, 0, 0), 1);
    add_row(unit_box(ONE, ONE, ONE, 0, 0, 0), 1);
    // every slab parallel: entry and exit both end at the most negative value
    add_row(unit_box(ONE + 1, ONE >> 1, ONE >> 1, 0, 0, 0), 1);
    add_row('{POS_MAX, POS_MAX, POS_MAX, NEG_MAX, NEG_MAX, NEG_MAX,
              NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX, POS_MAX, POS_MAX}, 2);
    add_row('{NEG_MAX, NEG_MAX, NEG_MAX, 1, 1, 1,
              POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX}, 2);
    add_row('{NEG_MAX, 0, POS_MAX, POS_MAX, 8, -8,
              POS_MAX, -1, NEG_MAX, NEG_MAX, 1, POS_MAX}, 2);
    add_row('{0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0}, 2);
    add_row('{-1, -1, -1, 7, -7, 8, 0, 0, 0, -1, -1, -1}, 2);
    add_row('{0, 0, 0, 1, 1, 1, POS_MAX, NEG_MAX, 0, POS_MAX, NEG_MAX, 1}, 2);
    add_row('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}, 2);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].expect_hit != 2 && predict_hit(rows[i].rb) != rows[i].expect_hit[0])
        report($sformatf("table row %0d disagrees with predictor", i));
      send_item(rows[i].rb);
    end
    drain();
    // random phases over several thresholds, extremes among them
    thr_set = '{16'd0, 16'hffff, 16'd1, 16'd300};
    for (int p = 0; p < 4; p++) begin
      write_threshold(p == 3 ? 16'($urandom) : thr_set[p]);
      repeat (NUM_RANDOM / 4) send_item(rand_ray_box());
      drain();
    end
    write_threshold(THR_RESET);
    repeat (30) send_item(rand_ray_box());
    drain();
    if (errors == 0) begin
      $display("[ray_box_slab_test] OK");
    end else begin
      $display("[ray_box_slab_test] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
